// ===== rtl/core/sma_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sparse matrix adder.
// Used by sma_ctrl, sma_dpath and the top level; depends on nothing.
package sma_pkg;

    localparam int ROW_W = 20;
    localparam int VAL_W = 32;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // Datapath operation codes issued by the controller.
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_SCAN_RD   = 5'd2;
    localparam logic [4:0] OP_IDX_INC   = 5'd3;
    localparam logic [4:0] OP_ADD_WR    = 5'd4;
    localparam logic [4:0] OP_DEL_START = 5'd5;
    localparam logic [4:0] OP_DEL_RD    = 5'd6;
    localparam logic [4:0] OP_DEL_WR    = 5'd7;
    localparam logic [4:0] OP_DEL_END   = 5'd8;
    localparam logic [4:0] OP_OVF       = 5'd9;
    localparam logic [4:0] OP_SHU_START = 5'd10;
    localparam logic [4:0] OP_SHU_RD    = 5'd11;
    localparam logic [4:0] OP_SHU_WR    = 5'd12;
    localparam logic [4:0] OP_INS_WR    = 5'd13;
    localparam logic [4:0] OP_EM_START  = 5'd14;
    localparam logic [4:0] OP_EM_RD     = 5'd15;
    localparam logic [4:0] OP_EM_LD     = 5'd16;
    localparam logic [4:0] OP_EM_EMPTY  = 5'd17;
    localparam logic [4:0] OP_EM_NEXT   = 5'd18;
    localparam logic [4:0] OP_CLEAR     = 5'd19;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic idx_eq_cnt;   // scan position reached the end of the table
        logic key_lt;       // slot key below incoming key
        logic key_eq;       // slot key equals incoming key
        logic sum_zero;     // saturated sum is zero
        logic val_zero;     // incoming value is zero
        logic full;         // table holds CAPACITY slots
        logic ptr_eq_idx;   // shift pointer reached the insert position
        logic del_end;      // no slot left above the pointer
        logic cnt_zero;     // table is empty
        logic out_last;     // output register holds the last result
        logic fin;          // held item is marked final
    } t_status;

endpackage

// ===== rtl/core/sma_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the sparse matrix adder: key/value memories, pointers, adder, output register.
// Depends on sma_pkg for operation codes and the status type.
module sma_dpath #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sma_pkg::t_cmd                  i_cmd,
    input  logic [sma_pkg::ROW_W-1:0]      i_row,
    input  logic [sma_pkg::ROW_W-1:0]      i_col,
    input  logic [sma_pkg::VAL_W-1:0]      i_value,
    input  logic                           i_fin,
    output sma_pkg::t_status               o_status,
    output logic [sma_pkg::ROW_W-1:0]      o_row,
    output logic [sma_pkg::ROW_W-1:0]      o_col,
    output logic [sma_pkg::VAL_W-1:0]      o_value,
    output logic                           o_present,
    output logic                           o_last,
    output logic                           o_ovf
);
    localparam int KW    = 2 * COORD_BITS;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RW    = sma_pkg::ROW_W;
    localparam int VW    = sma_pkg::VAL_W;

    logic [KW-1:0] r_key_mem [CAPACITY];
    logic [VW-1:0] r_val_mem [CAPACITY];

    logic [KW-1:0]    r_key, r_rd_key;
    logic [VW-1:0]    r_val, r_rd_val;
    logic             r_fin, r_ovf;
    logic [CNT_W-1:0] r_idx, r_ptr, r_count;

    logic [COORD_BITS+RW-1:0] row_ext, col_ext, orow_ext, ocol_ext;
    logic [CNT_W-1:0]         ptr_p1, ptr_m1;
    logic [VW:0]              sum_wide;
    logic [VW-1:0]            sum_sat;
    logic                     we, re;
    logic [AW-1:0]            wa, ra;
    logic [KW-1:0]            wkey;
    logic [VW-1:0]            wval;

    assign row_ext  = {{COORD_BITS{1'b0}}, i_row};
    assign col_ext  = {{COORD_BITS{1'b0}}, i_col};
    assign orow_ext = {{RW{1'b0}}, r_rd_key[KW-1:COORD_BITS]};
    assign ocol_ext = {{RW{1'b0}}, r_rd_key[COORD_BITS-1:0]};
    assign ptr_p1   = r_ptr + CNT_W'(1);
    assign ptr_m1   = r_ptr - CNT_W'(1);

    // Saturating Q16.16 add of the stored slot and the incoming value.
    assign sum_wide = {r_rd_val[VW-1], r_rd_val} + {r_val[VW-1], r_val};
    always_comb begin
        if (sum_wide[VW] != sum_wide[VW-1]) begin
            sum_sat = sum_wide[VW] ? sma_pkg::VAL_MIN : sma_pkg::VAL_MAX;
        end else begin
            sum_sat = sum_wide[VW-1:0];
        end
    end

    // Memory port selection.
    always_comb begin
        we   = 1'b0;
        re   = 1'b0;
        wa   = r_idx[AW-1:0];
        ra   = r_idx[AW-1:0];
        wkey = r_rd_key;
        wval = r_rd_val;
        unique case (i_cmd.op)
            sma_pkg::OP_SCAN_RD: re = 1'b1;
            sma_pkg::OP_DEL_RD: begin
                re = 1'b1;
                ra = ptr_p1[AW-1:0];
            end
            sma_pkg::OP_SHU_RD: begin
                re = 1'b1;
                ra = ptr_m1[AW-1:0];
            end
            sma_pkg::OP_EM_RD: begin
                re = 1'b1;
                ra = r_ptr[AW-1:0];
            end
            sma_pkg::OP_ADD_WR: begin
                we   = 1'b1;
                wval = sum_sat;
            end
            sma_pkg::OP_DEL_WR, sma_pkg::OP_SHU_WR: begin
                we = 1'b1;
                wa = r_ptr[AW-1:0];
            end
            sma_pkg::OP_INS_WR: begin
                we   = 1'b1;
                wkey = r_key;
                wval = r_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_key_mem[wa] <= wkey;
            r_val_mem[wa] <= wval;
        end
        if (re) begin
            r_rd_key <= r_key_mem[ra];
            r_rd_val <= r_val_mem[ra];
        end
    end

    // Held item and output payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sma_pkg::OP_LOAD: begin
                r_key <= {row_ext[COORD_BITS-1:0], col_ext[COORD_BITS-1:0]};
                r_val <= i_value;
                r_fin <= i_fin;
            end
            sma_pkg::OP_EM_LD: begin
                o_row     <= orow_ext[RW-1:0];
                o_col     <= ocol_ext[RW-1:0];
                o_value   <= r_rd_val;
                o_present <= 1'b1;
                o_ovf     <= r_ovf;
            end
            sma_pkg::OP_EM_EMPTY: begin
                o_row     <= '0;
                o_col     <= '0;
                o_value   <= '0;
                o_present <= 1'b0;
                o_ovf     <= r_ovf;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_ptr   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                sma_pkg::OP_LOAD:      r_idx <= '0;
                sma_pkg::OP_IDX_INC:   r_idx <= r_idx + CNT_W'(1);
                sma_pkg::OP_DEL_START: r_ptr <= r_idx;
                sma_pkg::OP_DEL_WR:    r_ptr <= ptr_p1;
                sma_pkg::OP_DEL_END:   r_count <= r_count - CNT_W'(1);
                sma_pkg::OP_OVF:       r_ovf <= 1'b1;
                sma_pkg::OP_SHU_START: r_ptr <= r_count;
                sma_pkg::OP_SHU_WR:    r_ptr <= ptr_m1;
                sma_pkg::OP_INS_WR:    r_count <= r_count + CNT_W'(1);
                sma_pkg::OP_EM_START:  r_ptr <= '0;
                sma_pkg::OP_EM_NEXT:   r_ptr <= ptr_p1;
                sma_pkg::OP_EM_LD:     o_last <= (ptr_p1 == r_count);
                sma_pkg::OP_EM_EMPTY:  o_last <= 1'b1;
                sma_pkg::OP_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.idx_eq_cnt = (r_idx == r_count);
    assign o_status.key_lt     = (r_rd_key < r_key);
    assign o_status.key_eq     = (r_rd_key == r_key);
    assign o_status.sum_zero   = (sum_sat == '0);
    assign o_status.val_zero   = (r_val == '0);
    assign o_status.full       = (r_count == CNT_W'(CAPACITY));
    assign o_status.ptr_eq_idx = (r_ptr == r_idx);
    assign o_status.del_end    = ({1'b0, ptr_p1} >= {1'b0, r_count});
    assign o_status.cnt_zero   = (r_count == '0);
    assign o_status.out_last   = o_last;
    assign o_status.fin        = r_fin;

endmodule

// ===== rtl/core/sma_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sparse matrix adder: sequences scan, update, shift and emit.
// Depends on sma_pkg for operation codes and the status type.
module sma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  sma_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output sma_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_ADD      = 4'd3;
    localparam logic [3:0] S_INS      = 4'd4;
    localparam logic [3:0] S_DEL_RD   = 4'd5;
    localparam logic [3:0] S_DEL_WR   = 4'd6;
    localparam logic [3:0] S_SHU_RD   = 4'd7;
    localparam logic [3:0] S_SHU_WR   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;
    localparam logic [3:0] S_EM_RD    = 4'd10;
    localparam logic [3:0] S_EM_LD    = 4'd11;
    localparam logic [3:0] S_EM_WAIT  = 4'd12;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EM_WAIT);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = sma_pkg::OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = sma_pkg::OP_LOAD;
                    n_state  = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.idx_eq_cnt) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.op = sma_pkg::OP_SCAN_RD;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.key_lt) begin
                    o_cmd.op = sma_pkg::OP_IDX_INC;
                    n_state  = S_SCAN_RD;
                end else if (i_status.key_eq) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_ADD: begin
                if (i_status.sum_zero) begin
                    o_cmd.op = sma_pkg::OP_DEL_START;
                    n_state  = S_DEL_RD;
                end else begin
                    o_cmd.op = sma_pkg::OP_ADD_WR;
                    n_state  = S_DONE;
                end
            end
            S_DEL_RD: begin
                if (i_status.del_end) begin
                    o_cmd.op = sma_pkg::OP_DEL_END;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = sma_pkg::OP_DEL_RD;
                    n_state  = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.op = sma_pkg::OP_DEL_WR;
                n_state  = S_DEL_RD;
            end
            S_INS: begin
                if (i_status.val_zero) begin
                    n_state = S_DONE;
                end else if (i_status.full) begin
                    o_cmd.op = sma_pkg::OP_OVF;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = sma_pkg::OP_SHU_START;
                    n_state  = S_SHU_RD;
                end
            end
            S_SHU_RD: begin
                if (i_status.ptr_eq_idx) begin
                    o_cmd.op = sma_pkg::OP_INS_WR;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = sma_pkg::OP_SHU_RD;
                    n_state  = S_SHU_WR;
                end
            end
            S_SHU_WR: begin
                o_cmd.op = sma_pkg::OP_SHU_WR;
                n_state  = S_SHU_RD;
            end
            S_DONE: begin
                if (!i_status.fin) begin
                    n_state = S_IDLE;
                end else if (i_status.cnt_zero) begin
                    o_cmd.op = sma_pkg::OP_EM_EMPTY;
                    n_state  = S_EM_WAIT;
                end else begin
                    o_cmd.op = sma_pkg::OP_EM_START;
                    n_state  = S_EM_RD;
                end
            end
            S_EM_RD: begin
                o_cmd.op = sma_pkg::OP_EM_RD;
                n_state  = S_EM_LD;
            end
            S_EM_LD: begin
                o_cmd.op = sma_pkg::OP_EM_LD;
                n_state  = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        o_cmd.op = sma_pkg::OP_CLEAR;
                        n_state  = S_IDLE;
                    end else begin
                        o_cmd.op = sma_pkg::OP_EM_NEXT;
                        n_state  = S_EM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/sparse_matrix_add.sv =====
`timescale 1ns / 1ps
// Top level of the sparse matrix adder: stream ports, controller and datapath.
// Depends on sma_pkg, sma_ctrl and sma_dpath.
//
// The block sums coordinate-list entries of two sparse matrices. Each input transfer
// carries one entry (row, column, Q16.16 value); it is merged into a table of up to
// CAPACITY slots kept sorted by (row, column): values with the same key are added with
// saturation, a slot whose sum becomes zero is removed, and a new key with a nonzero
// value is inserted in order or, when the table is full, dropped with the sticky
// overflow flag set. A transfer with tlast high is applied first, then the whole table
// is streamed out in ascending key order with tlast on the last result, and the table
// and flag are cleared; an empty table yields one result with entry_present low. Items
// are handled one at a time. The table sits in a single-port-read, single-port-write
// memory with registered read data, so each slot visited takes a read state and a check
// state; an item scans the slots up to its own, then moves slots one at a time when a
// slot is inserted or removed. The scan stops where the moves begin. Each result of the
// dump passes read, load and wait states and is held while the consumer holds tready
// low. Input is not accepted during a dump.
module sparse_matrix_add #(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // entry_row[19:0], entry_col[39:20], entry_value[71:40]
    input  logic        i_s_axis_tlast,  // final_entry
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // sum_row[19:0], sum_col[39:20], sum_value[71:40]
    output logic [1:0]  o_m_axis_tuser,  // entry_present[0], overflowed[1]
    output logic        o_m_axis_tlast   // last_result
);
    sma_pkg::t_cmd    cmd;
    sma_pkg::t_status status;

    logic [sma_pkg::ROW_W-1:0] out_row, out_col;
    logic [sma_pkg::VAL_W-1:0] out_value;
    logic                      out_present, out_last, out_ovf;

    sma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    sma_dpath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_row     (i_s_axis_tdata[19:0]),
        .i_col     (i_s_axis_tdata[39:20]),
        .i_value   (i_s_axis_tdata[71:40]),
        .i_fin     (i_s_axis_tlast),
        .o_status  (status),
        .o_row     (out_row),
        .o_col     (out_col),
        .o_value   (out_value),
        .o_present (out_present),
        .o_last    (out_last),
        .o_ovf     (out_ovf)
    );

    assign o_m_axis_tdata = {out_value, out_col, out_row};
    assign o_m_axis_tuser = {out_ovf, out_present};
    assign o_m_axis_tlast = out_last;

endmodule

// ===== rtl/core/sma_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sparse matrix adder, bound to the top level.
// Depends only on the ports of sparse_matrix_add.
module sma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    // A pending result's data and tlast hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Input and output never transfer in the same period of work.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("input ready during result dump");

    // An accepted item needs table work, so no result is valid in the next cycle.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_m_axis_tvalid)
        else $error("result right after input transfer");

    // The empty marker is always the last result and carries all-zero data.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("malformed empty marker");

    // After reset no result is pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sparse_matrix_add sma_checker u_sma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sparse_matrix_add: drives coordinate-list entries,
// predicts the sorted, saturated sums and checks every result transfer.
// Depends on sma_pkg and the sparse_matrix_add RTL.
module testbench;

    localparam int CAP      = 64;
    localparam int SETTLE   = 4 * CAP + 20;

    // One result as seen on the master side.
    typedef struct packed {
        logic [19:0] row;
        logic [19:0] col;
        logic [31:0] value;
        logic        present;
        logic        last;
        logic        ovf;
    } t_sum;

    // One row of the directed table; chk marks a row whose results are typed in.
    typedef struct {
        logic [19:0] row;
        logic [19:0] col;
        logic [31:0] value;
        logic        fin;
        bit          chk;
        t_sum        res;
    } t_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;  // entry_row[19:0], entry_col[39:20], entry_value[71:40]
    logic        i_s_axis_tlast;  // final_entry
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [71:0] o_m_axis_tdata;  // sum_row[19:0], sum_col[39:20], sum_value[71:40]
    logic [1:0]  o_m_axis_tuser;  // entry_present[0], overflowed[1]
    logic        o_m_axis_tlast;  // last_result

    sparse_matrix_add u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Predictor state: the sorted table and the sticky drop flag.
    logic [39:0] tbl_key [CAP];
    logic [31:0] tbl_val [CAP];
    int          tbl_cnt;
    bit          tbl_ovf;
    t_sum        sums_due[$];

    int  errors;
    int  mism_seen;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        longint s;
        s = longint'($signed(a)) + longint'($signed(b));
        if (s > 64'sd2147483647) return sma_pkg::VAL_MAX;
        if (s < -64'sd2147483648) return sma_pkg::VAL_MIN;
        return s[31:0];
    endfunction

    // Merge one entry into the table and queue the dump when it is final.
    task automatic merge_entry(logic [19:0] r, logic [19:0] c, logic [31:0] v, logic fin);
        logic [39:0] key;
        int          pos;
        key = {r, c};
        pos = 0;
        while (pos < tbl_cnt && tbl_key[pos] < key) pos++;
        if (pos < tbl_cnt && tbl_key[pos] == key) begin
            tbl_val[pos] = sat_sum(tbl_val[pos], v);
            if (tbl_val[pos] == 0) begin
                for (int i = pos; i + 1 < tbl_cnt; i++) begin
                    tbl_key[i] = tbl_key[i + 1];
                    tbl_val[i] = tbl_val[i + 1];
                end
                tbl_cnt--;
            end
        end else if (v != 0) begin
            if (tbl_cnt >= CAP) begin
                tbl_ovf = 1'b1;
            end else begin
                for (int i = tbl_cnt; i > pos; i--) begin
                    tbl_key[i] = tbl_key[i - 1];
                    tbl_val[i] = tbl_val[i - 1];
                end
                tbl_key[pos] = key;
                tbl_val[pos] = v;
                tbl_cnt++;
            end
        end
        if (fin) begin
            if (tbl_cnt == 0)
                sums_due.push_back('{20'd0, 20'd0, 32'd0, 1'b0, 1'b1, tbl_ovf});
            for (int k = 0; k < tbl_cnt; k++)
                sums_due.push_back('{tbl_key[k][39:20], tbl_key[k][19:0], tbl_val[k],
                                     1'b1, k == tbl_cnt - 1, tbl_ovf});
            tbl_cnt = 0;
            tbl_ovf = 1'b0;
        end
    endtask

    // Offer one entry, honoring the sender idle rate, and wait for its transfer.
    // tvalid stays high after the transfer; the next idle cycle or the caller drops it.
    task automatic send_entry(logic [19:0] r, logic [19:0] c, logic [31:0] v, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {v, c, r};
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        merge_entry(r, c, v, fin);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sums_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random value with plenty of zeros, extremes and small sums that cancel.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return sma_pkg::VAL_MAX;
            2:       return sma_pkg::VAL_MIN;
            3:       return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // A run of entries over a small coordinate window so that keys collide.
    task automatic random_run(int len, int span);
        logic [19:0] base_r;
        logic [19:0] base_c;
        base_r = 20'($urandom);
        base_c = 20'($urandom);
        for (int i = 0; i < len; i++)
            send_entry(20'(base_r + $urandom_range(span)), 20'(base_c + $urandom_range(span)),
                       rand_value(), i == len - 1);
    endtask

    // Receiver: random stalls, plus a long hold-off while hold_off is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_sum got;
        t_sum want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[19:0], o_m_axis_tdata[39:20], o_m_axis_tdata[71:40],
                    o_m_axis_tuser[0], o_m_axis_tlast, o_m_axis_tuser[1]};
            if (sums_due.size() == 0) begin
                errors++;
                if (mism_seen++ < 10)
                    $display("unexpected result: got %h", got);
            end else begin
                want = sums_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (mism_seen++ < 10)
                        $display("mismatch: row %h/%h col %h/%h val %h/%h pres %b/%b last %b/%b ovf %b/%b",
                                 want.row, got.row, want.col, got.col, want.value, got.value,
                                 want.present, got.present, want.last, got.last,
                                 want.ovf, got.ovf);
                end
            end
        end
    end

    // Directed rows; results are typed in for the empty marker and simple extremes.
    t_stim plan[$];

    initial begin
        int hold_cnt;
        t_sum none;
        none = '0;
        errors = 0;
        mism_seen = 0;
        tbl_cnt = 0;
        tbl_ovf = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table right after reset, then zero values never create a slot.
        plan.push_back('{20'd0, 20'd0, 32'd0, 1'b1, 1, '{0, 0, 0, 1'b0, 1'b1, 1'b0}});
        plan.push_back('{20'd5, 20'd5, 32'd0, 1'b1, 1, '{0, 0, 0, 1'b0, 1'b1, 1'b0}});
        // Extreme coordinates and values, single entry runs.
        plan.push_back('{20'hFFFFF, 20'hFFFFF, sma_pkg::VAL_MAX, 1'b1, 1,
                         '{20'hFFFFF, 20'hFFFFF, sma_pkg::VAL_MAX, 1'b1, 1'b1, 1'b0}});
        plan.push_back('{20'h00000, 20'hFFFFF, sma_pkg::VAL_MIN, 1'b1, 1,
                         '{20'h00000, 20'hFFFFF, sma_pkg::VAL_MIN, 1'b1, 1'b1, 1'b0}});
        // Positive and negative saturation, each on its own key.
        plan.push_back('{20'd3, 20'd4, sma_pkg::VAL_MAX, 1'b0, 0, none});
        plan.push_back('{20'd3, 20'd4, 32'd1, 1'b0, 0, none});
        plan.push_back('{20'd1, 20'd9, sma_pkg::VAL_MIN, 1'b0, 0, none});
        plan.push_back('{20'd1, 20'd9, 32'hFFFF_FFFF, 1'b1, 0, none});
        // Insertion order, zero value on an existing key, then a cancelled slot.
        plan.push_back('{20'd7, 20'd2, 32'h0001_0000, 1'b0, 0, none});
        plan.push_back('{20'd2, 20'd7, 32'h0002_0000, 1'b0, 0, none});
        plan.push_back('{20'd7, 20'd1, 32'h0003_0000, 1'b0, 0, none});
        plan.push_back('{20'd7, 20'd2, 32'd0, 1'b0, 0, none});
        plan.push_back('{20'd2, 20'd7, 32'hFFFE_0000, 1'b0, 0, none});
        plan.push_back('{20'd0, 20'd0, 32'h0000_8000, 1'b1, 0, none});
        // Everything cancels, so the final yields the empty marker.
        plan.push_back('{20'd9, 20'd9, 32'd5, 1'b0, 0, none});
        plan.push_back('{20'd9, 20'd9, 32'hFFFF_FFFB, 1'b1, 1, '{0, 0, 0, 1'b0, 1'b1, 1'b0}});

        foreach (plan[i]) begin
            send_entry(plan[i].row, plan[i].col, plan[i].value, plan[i].fin);
            if (plan[i].chk && (sums_due.size() != 1 || sums_due[0] != plan[i].res)) begin
                errors++;
                $display("directed row %0d: predictor disagrees with typed result", i);
            end
        end
        drain_results();

        // Fill the table past capacity: overflow flag, and adds to existing keys.
        for (int i = 0; i < CAP + 6; i++)
            send_entry(20'(i), 20'(i * 3), 32'(i + 1), 1'b0);
        send_entry(20'd0, 20'd0, 32'h10, 1'b0);
        send_entry(20'd4, 20'd12, 32'hFFFF_FFFB, 1'b1);
        drain_results();

        // Random phases with different idling.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 56) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 56) : 0;
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(4) == 0)
                    send_entry(20'($urandom), 20'($urandom), rand_value(),
                               1'($urandom_range(1)));
                else
                    random_run($urandom_range(1, 10), $urandom_range(1, 3));
            end
            // Sender pauses until every result has come.
            drain_results();
        end

        // Long receiver hold-off while a large dump is pending and input keeps coming.
        fork
            begin
                hold_off = 1'b1;
                hold_cnt = 0;
                while (hold_cnt < 600) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                hold_off = 1'b0;
            end
            begin
                random_run(20, 15);
                random_run(5, 1);
                i_s_axis_tvalid <= 1'b0;
            end
        join
        drain_results();

        if (errors == 0 && sums_due.size() == 0) begin
            $display("** sparse_matrix_add: PASSED **");
        end else begin
            $display("** sparse_matrix_add: FAILED **");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("** sparse_matrix_add: FAILED **");
        $finish;
    end
endmodule
